FILE: sv/eba_pkg.sv
// shared types and constants of the ergodicity breaking accumulator
package eba_pkg;

	localparam int NUM_LAGS_DEFAULT = 1024;
	localparam int LAG_W = 10;
	localparam int SAMPLE_W = 32;
	localparam int SUM_W = 48;
	localparam int SQ_W = 64;
	localparam int COUNT_W = 16;
	localparam int DIV_W = 96;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// largest ratio whose eb still fits below 2^31
	localparam logic [31:0] EB_RATIO_LIMIT = 32'h8000_FFFF;
	localparam logic [31:0] EB_ONE = 32'h0001_0000;
	localparam logic [31:0] EB_MAX = 32'h7FFF_FFFF;

	typedef struct packed {
		logic                op;
		logic [LAG_W-1:0]    lag_index;
		logic [SAMPLE_W-1:0] sample_value;
		logic                last_of_curve;
	} item_t;

	typedef struct packed {
		logic signed [31:0] eb_value;
		logic               no_curves;
		logic               saturated;
	} result_t;

	// classified command between front and back
	typedef struct packed {
		logic                query;
		logic                in_range;
		logic [LAG_W-1:0]    lag;
		logic [SAMPLE_W-1:0] sample;
		logic                last;
	} cmd_t;

endpackage

FILE: sv/eba_stream_if.sv
// valid/ready stream interface
interface eba_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/ergodicity_breaking_accumulator.sv
// top level of the ergodicity breaking moment accumulator
// usage:
// - item channel (sink) carries op, lag_index, sample_value, last_of_curve
// - op add accumulates sample_value and its square into the lag's sums;
//   last_of_curve also bumps the curve count, saturating at 65535
// - op query returns eb = n*sum_sq/sum^2 - 1 as signed q16.16 on the result
//   channel, with no_curves and a sticky saturated flag
// - an add whose lag is not below NUM_LAGS is dropped without a trace
// sequencing:
// - the front queues up to two commands; the back runs one at a time
// - an add occupies the back for its store read, square and write back
// - a query passes through pop, fetch, the steps on the shared 32x32
//   multiplier, divider start and the divider steps; its result is valid
//   once it is registered from the quotient
// - a query with no curves, or to an out-of-range or zero-sum lag, answers at fetch
// reset:
// - arst_n clears count and flags and starts a clearing pass that writes
//   zero to all NUM_LAGS store entries, one per cycle; item ready stays low
//   throughout the pass
// stall:
// - while a result waits on the receiver the back holds it in its output
//   register; the front keeps accepting transfers until its queue is full
module ergodicity_breaking_accumulator
	import eba_pkg::*;
#(
	parameter int NUM_LAGS = NUM_LAGS_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	eba_stream_if.sink    item,
	eba_stream_if.source  result
);

	// command path between front and back
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;
	logic clearing;

	// front: classify and queue each transfer
	eba_front #(
		.NUM_LAGS (NUM_LAGS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.clearing  (clearing),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// back: stores, accumulation and eb evaluation
	eba_back #(
		.NUM_LAGS (NUM_LAGS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.clearing  (clearing),
		.result    (result)
	);

endmodule

FILE: sv/eba_front.sv
// front end: accepts items, drops out-of-range adds, queues commands
module eba_front
	import eba_pkg::*;
#(
	parameter int NUM_LAGS = NUM_LAGS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	eba_stream_if.sink  item,
	input  logic        clearing,
	output logic        cmd_valid,
	output cmd_t        cmd,
	input  logic        cmd_pop
);

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       in_range;
	logic       take;
	logic       push;
	cmd_t       new_cmd;

	assign in_range = 32'(item.payload.lag_index) < 32'(NUM_LAGS);
	assign item.ready = (cnt_q != 2'd2) && !clearing;
	assign take = item.valid && item.ready;
	// an add outside the lag range leaves no trace
	assign push = take && !(item.payload.op == OP_ADD && !in_range);

	always_comb begin
		new_cmd.query = (item.payload.op == OP_QUERY);
		new_cmd.in_range = in_range;
		new_cmd.lag = item.payload.lag_index;
		new_cmd.sample = item.payload.sample_value;
		new_cmd.last = item.payload.last_of_curve;
	end

	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

endmodule

FILE: sv/eba_div.sv
// restoring divider, one quotient bit per cycle
module eba_div
	import eba_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] num,
	input  logic [DIV_W-1:0] den,
	output logic             done,
	output logic [DIV_W-1:0] quot
);

	localparam int CNT_W = $clog2(DIV_W);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] num_q;
	logic [DIV_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   shifted;
	logic [DIV_W:0]   diff;
	logic             ge;

	assign shifted = {rem_q, num_q[DIV_W-1]};
	assign diff = shifted - {1'b0, den_q};
	assign ge = shifted >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
			// quotient bits shift in behind the numerator
			num_q <= {num_q[DIV_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

FILE: sv/eba_back.sv
// back end: lag stores, read-modify-write of sums, eb evaluation
module eba_back
	import eba_pkg::*;
#(
	parameter int NUM_LAGS = NUM_LAGS_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  cmd_t          cmd,
	output logic          cmd_pop,
	output logic          clearing,
	eba_stream_if.source  result
);

	localparam int AW = (NUM_LAGS > 1) ? $clog2(NUM_LAGS) : 1;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_FETCH, ST_ADDWR, ST_QMUL, ST_DIVGO, ST_DIV, ST_RESP
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      clr_q;
	cmd_t               cur_q;
	logic [COUNT_W-1:0] count_q;
	logic               ovf_q;
	logic [2:0]         mstep_q;
	logic [63:0]        prod_q;
	logic [DIV_W-1:0]   den_q;
	logic [79:0]        num_q;
	logic               res_valid_q;
	result_t            res_q;

	logic [SUM_W-1:0]   sum_mem [NUM_LAGS];
	logic [SQ_W-1:0]    sq_mem [NUM_LAGS];
	logic [SUM_W-1:0]   rd_sum_q;
	logic [SQ_W-1:0]    rd_sq_q;

	logic               rd_en;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [SUM_W-1:0]   wr_sum;
	logic [SQ_W-1:0]    wr_sq;
	logic [SUM_W:0]     sum_ext;
	logic [SQ_W:0]      sq_ext;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        mul_p;
	logic               div_start;
	logic               div_done;
	logic [DIV_W-1:0]   div_quot;
	logic               clip;
	logic               go;

	assign clearing = (state_q == ST_CLEAR);
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign rd_en = cmd_pop;
	assign div_start = (state_q == ST_DIVGO);

	assign sum_ext = {1'b0, rd_sum_q} + {{(SUM_W+1-SAMPLE_W){1'b0}}, cur_q.sample};
	assign sq_ext = {1'b0, rd_sq_q} + {1'b0, prod_q};
	assign go = cur_q.in_range && (count_q != '0) && (rd_sum_q != '0);

	always_comb begin
		wr_en = 1'b0;
		wr_addr = AW'(cur_q.lag);
		wr_sum = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
		wr_sq = sq_ext[SQ_W] ? '1 : sq_ext[SQ_W-1:0];
		case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = clr_q;
				wr_sum = '0;
				wr_sq = '0;
			end
			ST_ADDWR: wr_en = 1'b1;
			default: wr_en = 1'b0;
		endcase
	end

	// one shared 32x32 multiplier: sample square, then S^2 and Q*N partials
	always_comb begin
		mul_a = cur_q.sample;
		mul_b = cur_q.sample;
		if (state_q == ST_QMUL) begin
			case (mstep_q)
				3'd0: begin
					mul_a = rd_sum_q[31:0];
					mul_b = rd_sum_q[31:0];
				end
				3'd1: begin
					mul_a = rd_sum_q[31:0];
					mul_b = {16'b0, rd_sum_q[47:32]};
				end
				3'd2: begin
					mul_a = {16'b0, rd_sum_q[47:32]};
					mul_b = {16'b0, rd_sum_q[47:32]};
				end
				3'd3: begin
					mul_a = rd_sq_q[31:0];
					mul_b = {16'b0, count_q};
				end
				default: begin
					mul_a = rd_sq_q[63:32];
					mul_b = {16'b0, count_q};
				end
			endcase
		end
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			sum_mem[wr_addr] <= wr_sum;
			sq_mem[wr_addr] <= wr_sq;
		end
		if (rd_en) begin
			rd_sum_q <= sum_mem[AW'(cmd.lag)];
			rd_sq_q <= sq_mem[AW'(cmd.lag)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
		if (state_q == ST_FETCH || (state_q == ST_QMUL && mstep_q != 3'd5)) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_QMUL) begin
			case (mstep_q)
				3'd1: den_q <= {32'b0, prod_q};
				3'd2: den_q <= den_q + (DIV_W'(prod_q[47:0]) << 33);
				3'd3: den_q <= den_q + {prod_q[31:0], 64'b0};
				3'd4: num_q <= {16'b0, prod_q};
				3'd5: num_q <= num_q + {prod_q[47:0], 32'b0};
				default: num_q <= num_q;
			endcase
		end
	end

	eba_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({num_q, 16'b0}),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign clip = (div_quot[DIV_W-1:32] != '0) || (div_quot[31:0] > EB_RATIO_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			count_q <= '0;
			ovf_q <= 1'b0;
			mstep_q <= 3'd0;
			res_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(NUM_LAGS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					mstep_q <= 3'd0;
					if (!cur_q.query) begin
						state_q <= ST_ADDWR;
					end else if (go) begin
						state_q <= ST_QMUL;
					end else begin
						res_q.eb_value <= '0;
						res_q.no_curves <= (count_q == '0);
						res_q.saturated <= ovf_q;
						res_valid_q <= 1'b1;
						state_q <= ST_RESP;
					end
				end
				ST_ADDWR: begin
					if (sum_ext[SUM_W] || sq_ext[SQ_W]) begin
						ovf_q <= 1'b1;
					end
					if (cur_q.last) begin
						if (count_q == '1) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
					state_q <= ST_IDLE;
				end
				ST_QMUL: begin
					mstep_q <= mstep_q + 3'd1;
					if (mstep_q == 3'd5) begin
						state_q <= ST_DIVGO;
					end
				end
				ST_DIVGO: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						res_q.eb_value <= clip ? EB_MAX : (div_quot[31:0] - EB_ONE);
						res_q.no_curves <= 1'b0;
						res_q.saturated <= ovf_q || clip;
						res_valid_q <= 1'b1;
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (result.ready) begin
						res_valid_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid = res_valid_q;
	assign result.payload = res_q;

	a_clear_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !cmd_pop)
		else $error("command popped during clearing pass");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLEAR) |=> (count_q >= $past(count_q)))
		else $error("curve count decreased");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=> (state_q == ST_RESP))
		else $error("back end moved on with a result pending");

endmodule

FILE: sim/tb_ergodicity_breaking_accumulator.sv
// self-checking testbench of the ergodicity breaking moment accumulator
module tb_ergodicity_breaking_accumulator
	import eba_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LAGS = NUM_LAGS_DEFAULT;
	localparam longint unsigned CYCLE_LIMIT = 64'd3_000_000;

	logic clk;
	logic arst_n;

	eba_stream_if #(.payload_t(item_t))   item_ch();
	eba_stream_if #(.payload_t(result_t)) result_ch();

	ergodicity_breaking_accumulator #(.NUM_LAGS(LAGS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch.sink),
		.result(result_ch.source)
	);

	// predictor state: per-lag moment sums, curve count, sticky overflow
	logic [SUM_W-1:0]   lag_sum [LAGS];
	logic [SQ_W-1:0]    lag_square_sum [LAGS];
	logic [COUNT_W-1:0] curves;
	logic               clipped_ever;

	result_t eb_pending [$];

	int  send_idle_pct;
	int  recv_idle_pct;
	int  error_count;
	longint unsigned cycle_count;

	// advance the predictor by one item; queries push the expected eb
	task automatic predict_item(input item_t it);
		logic [SUM_W:0]    sum_next;
		logic [SQ_W:0]     square_next;
		logic [SQ_W-1:0]   square;
		logic [127:0]      numer;
		logic [127:0]      denom;
		logic [127:0]      ratio;
		result_t           r;
		begin
			if (it.op == OP_ADD) begin
				if (it.lag_index < LAGS) begin
					sum_next = {1'b0, lag_sum[it.lag_index]}
						+ {{(SUM_W+1-SAMPLE_W){1'b0}}, it.sample_value};
					if (sum_next[SUM_W]) begin
						lag_sum[it.lag_index] = '1;
						clipped_ever = 1'b1;
					end else begin
						lag_sum[it.lag_index] = sum_next[SUM_W-1:0];
					end
					square = {32'd0, it.sample_value} * {32'd0, it.sample_value};
					square_next = {1'b0, lag_square_sum[it.lag_index]} + {1'b0, square};
					if (square_next[SQ_W]) begin
						lag_square_sum[it.lag_index] = '1;
						clipped_ever = 1'b1;
					end else begin
						lag_square_sum[it.lag_index] = square_next[SQ_W-1:0];
					end
					if (it.last_of_curve) begin
						if (curves == '1)
							clipped_ever = 1'b1;
						else
							curves = curves + 1'b1;
					end
				end
			end else begin
				r.eb_value = '0;
				r.no_curves = (curves == 0);
				r.saturated = clipped_ever;
				if (it.lag_index < LAGS && curves != 0 && lag_sum[it.lag_index] != 0) begin
					// exact ratio in q16.16: n * q * 2^16 / s^2
					numer = ({64'd0, lag_square_sum[it.lag_index]} * {112'd0, curves}) << 16;
					denom = {80'd0, lag_sum[it.lag_index]} * {80'd0, lag_sum[it.lag_index]};
					ratio = numer / denom;
					if (ratio > {96'd0, EB_RATIO_LIMIT}) begin
						r.eb_value = EB_MAX;
						r.saturated = 1'b1;
					end else begin
						r.eb_value = ratio[31:0] - EB_ONE;
					end
				end
				eb_pending.push_back(r);
			end
		end
	endtask

	// one transfer on the item channel, with random gaps before it
	task automatic send_item(input item_t it);
		begin
			while ($urandom_range(99) < send_idle_pct) begin
				item_ch.valid <= 1'b0;
				@(negedge clk);
			end
			item_ch.payload <= it;
			item_ch.valid <= 1'b1;
			@(posedge clk);
			while (!item_ch.ready)
				@(posedge clk);
			predict_item(it);
			@(negedge clk);
		end
	endtask

	task automatic send_add(input int lag, input logic [31:0] sample, input logic last);
		item_t it;
		begin
			it.op = OP_ADD;
			it.lag_index = lag[LAG_W-1:0];
			it.sample_value = sample;
			it.last_of_curve = last;
			send_item(it);
		end
	endtask

	// query with random don't-care fields
	task automatic send_query(input int lag);
		item_t it;
		begin
			it.op = OP_QUERY;
			it.lag_index = lag[LAG_W-1:0];
			it.sample_value = $urandom;
			it.last_of_curve = 1'($urandom_range(1));
			send_item(it);
		end
	endtask

	task automatic wait_drained();
		begin
			item_ch.valid <= 1'b0;
			while (eb_pending.size() != 0)
				@(negedge clk);
			repeat (150) @(negedge clk);
		end
	endtask

	// reset state, empty lag, zero sum, no curves
	task automatic test_empty_state();
		begin
			send_query(0);
			send_query(LAGS - 1);
			send_add(5, 32'd0, 1'b0);
			send_query(5);
			send_add(6, 32'h0001_0000, 1'b1);
			send_query(6);
			send_query(5);
		end
	endtask

	// constant samples give eb zero; spread gives positive eb; extreme fields
	task automatic test_directed_moments();
		begin
			send_add(10, 32'h0002_0000, 1'b0);
			send_add(10, 32'h0002_0000, 1'b1);
			send_query(10);
			send_add(11, 32'h0000_0001, 1'b0);
			send_add(11, 32'hFFFF_FFFF, 1'b1);
			send_query(11);
			send_add(1023, 32'hFFFF_FFFF, 1'b1);
			send_query(1023);
			send_add(12, 32'h0000_0001, 1'b1);
			send_query(12);
			send_query(11);
		end
	endtask

	// hammer lag 3 with large samples so the square sum clips
	task automatic test_sum_overflow();
		begin
			repeat (6) send_add(3, 32'hFFFF_FFFF, 1'b0);
			send_query(3);
			send_query(10);
		end
	endtask

	// mostly adds with random content across a small hot set of lags
	task automatic test_random_items(input int count);
		int lag;
		logic [31:0] sample;
		begin
			for (int k = 0; k < count; k++) begin
				lag = ($urandom_range(3) == 0) ? $urandom_range(LAGS - 1) : $urandom_range(15);
				if ($urandom_range(6) == 0) begin
					send_query(lag);
				end else begin
					case ($urandom_range(3))
						0: sample = $urandom;
						1: sample = $urandom_range(32'h0004_0000);
						2: sample = {16'($urandom_range(255)), 16'($urandom)};
						default: sample = 32'h0001_0000 + $urandom_range(4095);
					endcase
					send_add(lag, sample, $urandom_range(3) == 0);
				end
			end
		end
	endtask

	// run of curve ends on two lags with very different samples, then queries
	task automatic test_curve_run();
		begin
			for (int k = 0; k < 40; k++)
				send_add(20 + (k % 2), 32'h0000_0001 + (k % 2) * 32'h0000_FFFF, 1'b1);
			send_query(20);
			send_query(21);
			send_query(LAGS - 1);
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// cycle guard
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("ergodicity_breaking_accumulator test failed");
				$finish;
			end
		end
	end

	// receiver: random stalls, checks each result transfer against the oldest prediction
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.payload;
			if (eb_pending.size() == 0) begin
				$error("unexpected result transfer eb_value=%0d", got.eb_value);
				error_count++;
			end else begin
				want = eb_pending.pop_front();
				if (got.eb_value !== want.eb_value) begin
					$error("eb_value expected %0d actual %0d", want.eb_value, got.eb_value);
					error_count++;
				end
				if (got.no_curves !== want.no_curves) begin
					$error("no_curves expected %0b actual %0b", want.no_curves, got.no_curves);
					error_count++;
				end
				if (got.saturated !== want.saturated) begin
					$error("saturated expected %0b actual %0b", want.saturated, got.saturated);
					error_count++;
				end
			end
		end
	end

	initial begin
		error_count = 0;
		send_idle_pct = 28;
		recv_idle_pct = 63;
		for (int k = 0; k < LAGS; k++) begin
			lag_sum[k] = '0;
			lag_square_sum[k] = '0;
		end
		curves = '0;
		clipped_ever = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.payload = '0;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_empty_state();
		test_directed_moments();
		test_random_items(270);
		send_idle_pct = 63;
		recv_idle_pct = 28;
		test_random_items(270);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_items(270);
		test_sum_overflow();
		test_curve_run();
		test_random_items(50);

		wait_drained();
		if (error_count == 0)
			$display("ergodicity_breaking_accumulator test passed");
		else
			$display("ergodicity_breaking_accumulator test failed");
		$finish;
	end
endmodule
